// ===== design/lpfd_pkg.sv =====
// Package for the length-prefixed frame deframer.
// Holds the phase, link and kind codes, the frame type constants and the result struct.
package lpfd_pkg;

    localparam logic [15:0] MAX_FRAME_LEN_RESET = 16'd512;

    localparam logic [7:0] TYPE_READY  = 8'h03;
    localparam logic [7:0] TYPE_REJECT = 8'h04;
    localparam logic [7:0] TYPE_PING   = 8'h11;

    localparam logic FUNC_BYTE    = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    typedef enum logic [1:0] {
        PH_LEN_HI = 2'd0,
        PH_LEN_LO = 2'd1,
        PH_BODY   = 2'd2,
        PH_HALT   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        LINK_OFF        = 2'd0,
        LINK_CONNECTING = 2'd1,
        LINK_ONLINE     = 2'd2,
        LINK_ERROR      = 2'd3
    } link_t;

    typedef enum logic [1:0] {
        KIND_TYPE    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_BAD_LEN = 2'd2
    } kind_t;

    typedef struct packed {
        logic        pong_request;
        link_t       link_state;
        logic        last;
        logic [7:0]  frame_type;
        logic [7:0]  data_byte;
        kind_t       kind;
    } result_t;

endpackage

// ===== design/lpfd_parser.sv =====
// Frame parser: length prefix decode, body byte tagging and link state tracking.
// Depends on lpfd_pkg for codes, constants and the result struct.
module lpfd_parser
    import lpfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        item_fire,
    input  logic        func,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    output result_t     res
);

    logic [15:0] max_frame_len_reg;
    phase_t      phase_reg, phase_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] bytes_received_reg, bytes_received_next;
    logic [7:0]  current_type_reg, current_type_next;
    link_t       link_mode_reg, link_mode_next;

    logic [15:0] len_word;
    logic [15:0] count_inc;
    logic [7:0]  type_now;
    logic        is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_len_reg  <= MAX_FRAME_LEN_RESET;
            phase_reg          <= PH_LEN_HI;
            length_high_reg    <= 8'd0;
            frame_length_reg   <= 16'd0;
            bytes_received_reg <= 16'd0;
            current_type_reg   <= 8'd0;
            link_mode_reg      <= LINK_OFF;
        end
        else
        begin
            if (cfg_we)
            begin
                max_frame_len_reg <= cfg_data;
            end
            phase_reg          <= phase_next;
            length_high_reg    <= length_high_next;
            frame_length_reg   <= frame_length_next;
            bytes_received_reg <= bytes_received_next;
            current_type_reg   <= current_type_next;
            link_mode_reg      <= link_mode_next;
        end
    end

    assign len_word  = {length_high_reg, rx_byte};
    assign count_inc = bytes_received_reg + 16'd1;
    assign type_now  = (bytes_received_reg == 16'd0) ? rx_byte : current_type_reg;
    assign is_last   = (count_inc >= frame_length_reg);

    always_comb
    begin
        phase_next          = phase_reg;
        length_high_next    = length_high_reg;
        frame_length_next   = frame_length_reg;
        bytes_received_next = bytes_received_reg;
        current_type_next   = current_type_reg;
        link_mode_next      = link_mode_reg;
        res_valid           = 1'b0;
        res.kind            = KIND_BAD_LEN;
        res.data_byte       = 8'd0;
        res.frame_type      = 8'd0;
        res.last            = 1'b0;
        res.link_state      = link_mode_reg;
        res.pong_request    = 1'b0;

        if (item_fire)
        begin
            if (func == FUNC_RESTART)
            begin
                phase_next          = PH_LEN_HI;
                length_high_next    = 8'd0;
                frame_length_next   = 16'd0;
                bytes_received_next = 16'd0;
                current_type_next   = 8'd0;
                link_mode_next      = LINK_CONNECTING;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEN_HI:
                    begin
                        length_high_next = rx_byte;
                        phase_next       = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        if ((len_word == 16'd0) || (len_word > max_frame_len_reg))
                        begin
                            phase_next = PH_HALT;
                            res_valid  = 1'b1;
                        end
                        else
                        begin
                            frame_length_next   = len_word;
                            bytes_received_next = 16'd0;
                            phase_next          = PH_BODY;
                        end
                    end
                    PH_BODY:
                    begin
                        res_valid           = 1'b1;
                        current_type_next   = type_now;
                        bytes_received_next = count_inc;
                        res.kind            = (bytes_received_reg == 16'd0) ? KIND_TYPE
                                                                            : KIND_PAYLOAD;
                        res.data_byte       = rx_byte;
                        res.frame_type      = type_now;
                        res.last            = is_last;
                        if (is_last)
                        begin
                            if (type_now == TYPE_READY)
                            begin
                                link_mode_next = LINK_ONLINE;
                            end
                            else if (type_now == TYPE_REJECT)
                            begin
                                link_mode_next = LINK_ERROR;
                            end
                            else if (type_now == TYPE_PING)
                            begin
                                res.pong_request = 1'b1;
                            end
                            phase_next          = PH_LEN_HI;
                            frame_length_next   = 16'd0;
                            bytes_received_next = 16'd0;
                        end
                        res.link_state = link_mode_next;
                    end
                    PH_HALT:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== design/lpfd_out_skid.sv =====
// Result register with a skid stage; the input waits only while the skid stage is full.
// Depends on lpfd_pkg for the result struct.
module lpfd_out_skid
    import lpfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg, skid_data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            out_valid_next  = skid_valid_reg || push;
            out_data_next   = skid_valid_reg ? skid_data_reg : push_data;
            skid_valid_next = 1'b0;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/length_prefixed_frame_deframer.sv =====
// Top level of the length-prefixed frame deframer.
// Depends on lpfd_pkg, lpfd_parser and lpfd_out_skid.
//
// The block takes one received stream byte (or a link restart) per item and accepts an
// item in every clock cycle while s_axis_tready is high; items are decoded combinationally
// by the parser, and each result is registered in the result register or the skid stage
// behind it, which keeps s_axis_tready registered, so a stalled output holds the input off
// only once two results are waiting. Frames are a big-endian 16-bit length followed by a
// type byte and payload; lengths of zero or above max_frame_len give one error result and
// the stream is then ignored until a restart. The max_frame_len register resets to 512 and
// should be written only while the block is idle.
module length_prefixed_frame_deframer
    import lpfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,       // max_frame_len[15:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    input  logic        s_axis_tuser,   // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // data_byte[7:0], frame_type[15:8],
                                        // link_state[17:16], pong_request[18], zero[23:19]
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast    // last
);

    logic    item_fire;
    logic    space;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = space;
    assign item_fire     = s_axis_tvalid && space;

    lpfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .item_fire (item_fire),
        .func      (s_axis_tuser),
        .rx_byte   (s_axis_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    lpfd_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_res)
    );

    assign m_axis_tdata = {5'd0, out_res.pong_request, out_res.link_state,
                           out_res.frame_type, out_res.data_byte};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for length_prefixed_frame_deframer.
// Drives stream bytes and restarts, predicts each result in its own frame model or takes a typed-in one, and
// compares field by field; depends on lpfd_pkg and the deframer RTL.
module testbench;
    import lpfd_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic       fn;
        logic [7:0] b;
        logic       typed;
        result_t    res;
    } row_t;

    localparam result_t NO_RES = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int send_idle = 0;
    int recv_idle = 0;
    bit hold_req = 1'b0;
    int errors = 0;
    int items_sent = 0;
    int results_due = 0;

    result_t expected_results[$];

    phase_t      phase_q = PH_LEN_HI;
    logic [7:0]  len_hi_q = '0;
    logic [15:0] frame_len_q = '0;
    logic [15:0] body_cnt_q = '0;
    logic [15:0] max_len_q = MAX_FRAME_LEN_RESET;
    logic [7:0]  type_q = '0;
    link_t       link_q = LINK_OFF;

    // The expected result is typed in where it is obvious; other rows use the frame model.
    row_t plan [25] = '{
        '{FUNC_BYTE,    8'h00, 1'b0, NO_RES},
        '{FUNC_BYTE,    8'h02, 1'b0, NO_RES},
        '{FUNC_BYTE,    8'h03, 1'b1, '{1'b0, LINK_OFF, 1'b0, 8'h03, 8'h03, KIND_TYPE}},
        '{FUNC_BYTE,    8'hFF, 1'b1, '{1'b0, LINK_ONLINE, 1'b1, 8'h03, 8'hFF, KIND_PAYLOAD}},
        '{FUNC_RESTART, 8'hFF, 1'b0, NO_RES},
        '{FUNC_BYTE,    8'h00, 1'b0, NO_RES},
        '{FUNC_BYTE,    8'h01, 1'b0, NO_RES},
        '{FUNC_BYTE,    8'h11, 1'b1, '{1'b1, LINK_CONNECTING, 1'b1, 8'h11, 8'h11, KIND_TYPE}},
        '{FUNC_BYTE,    8'h00, 1'b0, NO_RES},
        '{FUNC_BYTE,    8'h01, 1'b0, NO_RES},
        '{FUNC_BYTE,    8'h04, 1'b1, '{1'b0, LINK_ERROR, 1'b1, 8'h04, 8'h04, KIND_TYPE}},
        '{FUNC_BYTE,    8'h00, 1'b0, NO_RES},
        '{FUNC_BYTE,    8'h01, 1'b0, NO_RES},
        '{FUNC_BYTE,    8'hA5, 1'b1, '{1'b0, LINK_ERROR, 1'b1, 8'hA5, 8'hA5, KIND_TYPE}},
        '{FUNC_BYTE,    8'h02, 1'b0, NO_RES},
        '{FUNC_BYTE,    8'h01, 1'b1, '{1'b0, LINK_ERROR, 1'b0, 8'h00, 8'h00, KIND_BAD_LEN}},
        '{FUNC_BYTE,    8'h55, 1'b0, NO_RES},
        '{FUNC_BYTE,    8'h00, 1'b0, NO_RES},
        '{FUNC_RESTART, 8'h00, 1'b0, NO_RES},
        '{FUNC_BYTE,    8'h00, 1'b0, NO_RES},
        '{FUNC_BYTE,    8'h00, 1'b1, '{1'b0, LINK_CONNECTING, 1'b0, 8'h00, 8'h00, KIND_BAD_LEN}},
        '{FUNC_RESTART, 8'hFF, 1'b0, NO_RES},
        '{FUNC_BYTE,    8'hFF, 1'b0, NO_RES},
        '{FUNC_BYTE,    8'hFF, 1'b1, '{1'b0, LINK_CONNECTING, 1'b0, 8'h00, 8'h00, KIND_BAD_LEN}},
        '{FUNC_RESTART, 8'h00, 1'b0, NO_RES}
    };

    length_prefixed_frame_deframer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    function automatic bit deframe_step(input logic fn, input logic [7:0] b,
                                        output result_t r);
        logic [15:0] len;
        bit          first;
        bit          done;
        r = '0;
        len = {len_hi_q, b};
        if (fn == FUNC_RESTART)
        begin
            phase_q = PH_LEN_HI;
            len_hi_q = '0;
            frame_len_q = '0;
            body_cnt_q = '0;
            type_q = '0;
            link_q = LINK_CONNECTING;
            return 1'b0;
        end
        case (phase_q)
            PH_LEN_HI:
            begin
                len_hi_q = b;
                phase_q = PH_LEN_LO;
                return 1'b0;
            end
            PH_LEN_LO:
            begin
                if (len == 16'd0 || len > max_len_q)
                begin
                    phase_q = PH_HALT;
                    r.kind = KIND_BAD_LEN;
                    r.link_state = link_q;
                    return 1'b1;
                end
                frame_len_q = len;
                body_cnt_q = '0;
                phase_q = PH_BODY;
                return 1'b0;
            end
            PH_BODY:
            begin
                first = (body_cnt_q == 16'd0);
                if (first)
                    type_q = b;
                body_cnt_q = body_cnt_q + 16'd1;
                done = (body_cnt_q >= frame_len_q);
                r.kind = first ? KIND_TYPE : KIND_PAYLOAD;
                r.data_byte = b;
                r.frame_type = type_q;
                r.last = done;
                if (done)
                begin
                    if (type_q == TYPE_READY)
                        link_q = LINK_ONLINE;
                    else if (type_q == TYPE_REJECT)
                        link_q = LINK_ERROR;
                    else if (type_q == TYPE_PING)
                        r.pong_request = 1'b1;
                    phase_q = PH_LEN_HI;
                    frame_len_q = '0;
                    body_cnt_q = '0;
                end
                r.link_state = link_q;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_item(input logic fn, input logic [7:0] b,
                             input bit typed = 1'b0, input result_t typed_res = '0);
        result_t r;
        bit      has_res;
        if ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= fn;
        do @(posedge clk); while (!s_axis_tready);
        has_res = deframe_step(fn, b, r);
        items_sent++;
        if (has_res)
        begin
            results_due++;
            expected_results.push_back(typed ? typed_res : r);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    task automatic write_max_len(input logic [15:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_len_q = value;
    endtask

    task automatic send_frame(input int len, input bit may_cut);
        logic [7:0] ftype;
        int         cut;
        case ($urandom_range(3))
            0: ftype = TYPE_READY;
            1: ftype = TYPE_REJECT;
            2: ftype = TYPE_PING;
            default: ftype = 8'($urandom_range(255));
        endcase
        send_item(FUNC_BYTE, len[15:8]);
        send_item(FUNC_BYTE, len[7:0]);
        if (phase_q == PH_HALT)
        begin
            repeat ($urandom_range(2)) send_item(FUNC_BYTE, 8'($urandom_range(255)));
            send_item(FUNC_RESTART, 8'($urandom_range(255)));
        end
        else
        begin
            cut = (may_cut && $urandom_range(99) < 5) ? $urandom_range(len - 1) : len;
            for (int i = 0; i < cut; i++)
                send_item(FUNC_BYTE, i == 0 ? ftype : 8'($urandom_range(255)));
            if (cut < len)
                send_item(FUNC_RESTART, 8'($urandom_range(255)));
        end
    endtask

    task automatic run_random();
        int items0;
        int results0;
        int p;
        int len;
        items0 = items_sent;
        results0 = results_due;
        while (items_sent - items0 < 250 || results_due - results0 < 40)
        begin
            p = $urandom_range(99);
            if (p < 4)
                send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
            else if (p < 7)
                send_item(FUNC_RESTART, 8'($urandom_range(255)));
            else if (p < 8)
                drain_results();
            else
            begin
                p = $urandom_range(99);
                if (p < 70)
                    len = $urandom_range(6, 1);
                else if (p < 80 && max_len_q <= 16'd600)
                    len = max_len_q;
                else if (p < 90 && max_len_q < 16'hFFFF)
                    len = max_len_q + 1;
                else if (p < 95)
                    len = 0;
                else if (max_len_q < 16'hFFFF)
                    len = $urandom_range(65535, max_len_q + 1);
                else
                    len = $urandom_range(6, 1);
                send_frame(len, 1'b1);
            end
        end
    endtask

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with none expected", m_axis_tdata, 0);
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tuser != want.kind)
                    report_mismatch("kind", m_axis_tuser, want.kind);
                if (m_axis_tdata[7:0] != want.data_byte)
                    report_mismatch("data_byte", m_axis_tdata[7:0], want.data_byte);
                if (m_axis_tdata[15:8] != want.frame_type)
                    report_mismatch("frame_type", m_axis_tdata[15:8], want.frame_type);
                if (m_axis_tlast != want.last)
                    report_mismatch("last", m_axis_tlast, want.last);
                if (m_axis_tdata[17:16] != want.link_state)
                    report_mismatch("link_state", m_axis_tdata[17:16], want.link_state);
                if (m_axis_tdata[18] != want.pong_request)
                    report_mismatch("pong_request", m_axis_tdata[18], want.pong_request);
                if (m_axis_tdata[23:19] != 5'd0)
                    report_mismatch("padding", m_axis_tdata[23:19], 0);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle = 31;
        recv_idle = 61;
        foreach (plan[i])
            send_item(plan[i].fn, plan[i].b, plan[i].typed, plan[i].res);
        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg)
                0: write_max_len(16'd1);
                1: write_max_len(16'd0);
                2: write_max_len(16'd3);
                3: write_max_len(MAX_FRAME_LEN_RESET);
                4: write_max_len(16'($urandom_range(700, 4)));
                default: write_max_len(16'hFFFF);
            endcase
            if (seg == 2)
            begin
                send_idle = 61;
                recv_idle = 31;
            end
            if (seg == 4)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            // The output is held off for a long stretch while bytes keep being offered at the input.
            if (seg == 3)
                hold_req = 1'b1;
            run_random();
        end
        send_frame(6, 1'b0);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", expected_results.size(), 0);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
